// ===== rtl/core/flow_q_vector_accumulator_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the flow Q-vector accumulator
// Wrappers for concurrent assertions on clk/arst_n.
// ----------------------------------------------------------------------------
`ifndef FLOW_Q_VECTOR_ACCUMULATOR_DEFINES_SVH
`define FLOW_Q_VECTOR_ACCUMULATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FQVA_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define FQVA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/fqva_pkg.sv =====
// ----------------------------------------------------------------------------
// fqva_pkg
// Types, constants and arithmetic helpers of the flow Q-vector accumulator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fqva_pkg;

	localparam int MAX_BINS      = 16;
	localparam int MAX_HARMONICS = 8;
	localparam int MAX_POWERS    = 8;

	localparam int BIN_W  = $clog2(MAX_BINS);
	localparam int HARM_W = $clog2(MAX_HARMONICS);
	localparam int POW_W  = $clog2(MAX_POWERS);
	localparam int ADDR_W = BIN_W + HARM_W + POW_W;
	localparam int DEPTH  = MAX_BINS * MAX_HARMONICS * MAX_POWERS;

	localparam int SUM_W  = 48;
	localparam int PRE_W  = 32;
	localparam int TRIG_W = 16;
	localparam int CX_W   = 34;
	localparam int Z_W    = 18;
	localparam int ITER_W = 4;
	localparam int CORDIC_STEPS = 14;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_HARMONICS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BINS      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_POWERS    = 2'd2;

	localparam logic [3:0]  HARM_RESET   = 4'd1;
	localparam logic [4:0]  BINS_RESET   = 5'd1;
	localparam logic [31:0] POWERS_RESET = 32'd286331153;

	localparam logic [1:0] OP_FILL  = 2'd0;
	localparam logic [1:0] OP_CLEAR = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;
	localparam logic [1:0] OP_NOP   = 2'd3;

	localparam logic [PRE_W-1:0] ONE_Q12 = 32'd4096;
	localparam logic signed [CX_W-1:0] CORDIC_X0 = 34'sd652032874;

	typedef struct packed {
		logic [1:0]        operation;
		logic [15:0]       angle;
		logic [3:0]        bin_index;
		logic [15:0]       weight;
		logic [15:0]       second_weight;
		logic signed [3:0] read_harmonic;
		logic [2:0]        read_power;
	} item_t;

	typedef struct packed {
		logic signed [SUM_W-1:0] sum_real;
		logic signed [SUM_W-1:0] sum_imag;
		logic                    bin_filled;
		logic [31:0]             fill_count;
	} result_t;

	typedef struct packed {
		logic              load_fill;
		logic              clear_all;
		logic              pre_step;
		logic              trig_init;
		logic              trig_step;
		logic              trig_fin;
		logic              next_h;
		logic              mem_re;
		logic              mem_we;
		logic              clr_wr;
		logic              mul;
		logic              load_out;
		logic [ADDR_W-1:0] addr;
		logic [POW_W-1:0]  p;
		logic [ITER_W-1:0] iter;
		logic [BIN_W-1:0]  bin;
		logic              read_ok;
		logic              read_conj;
	} cmd_t;

	typedef struct packed {
		logic out_busy;
	} status_t;

	function automatic logic signed [Z_W-1:0] atan_step(input logic [ITER_W-1:0] i);
		logic signed [Z_W-1:0] v;
		case (i)
			4'd0:    v = 18'sd8192;
			4'd1:    v = 18'sd4836;
			4'd2:    v = 18'sd2555;
			4'd3:    v = 18'sd1297;
			4'd4:    v = 18'sd651;
			4'd5:    v = 18'sd326;
			4'd6:    v = 18'sd163;
			4'd7:    v = 18'sd81;
			4'd8:    v = 18'sd41;
			4'd9:    v = 18'sd20;
			4'd10:   v = 18'sd10;
			4'd11:   v = 18'sd5;
			4'd12:   v = 18'sd3;
			4'd13:   v = 18'sd1;
			default: v = 18'sd0;
		endcase
		return v;
	endfunction

	// Q.12 product, rounded half up and saturated to 32 bits.
	function automatic logic [PRE_W-1:0] qmul(input logic [PRE_W-1:0] a, input logic [15:0] b);
		logic [48:0] prod;
		logic [36:0] r;
		prod = 49'(a) * 49'(b) + 49'd2048;
		r = prod[48:12];
		return (r > 37'h0FFFFFFFF) ? {PRE_W{1'b1}} : r[PRE_W-1:0];
	endfunction

endpackage

// ===== rtl/core/fqva_ctrl.sv =====
// ----------------------------------------------------------------------------
// fqva_ctrl
// Sequencer: configuration registers, loop counters and datapath commands.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "flow_q_vector_accumulator_defines.svh"

module fqva_ctrl (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           item_valid,
	output logic                           item_ready,
	input  fqva_pkg::item_t                item,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [fqva_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                    cfg_data,
	output fqva_pkg::cmd_t                 cmd,
	input  fqva_pkg::status_t              status
);
	import fqva_pkg::*;

	typedef enum logic [10:0] {
		ST_CLEAR = 11'b00000000001,
		ST_IDLE  = 11'b00000000010,
		ST_PRE   = 11'b00000000100,
		ST_TSET  = 11'b00000001000,
		ST_TRIG  = 11'b00000010000,
		ST_TFIN  = 11'b00000100000,
		ST_RD    = 11'b00001000000,
		ST_MUL   = 11'b00010000000,
		ST_WR    = 11'b00100000000,
		ST_RREQ  = 11'b01000000000,
		ST_RRES  = 11'b10000000000
	} state_t;

	state_t            state_q;
	logic [ADDR_W-1:0] cnt_q;
	logic [HARM_W:0]   h_q;
	logic [POW_W:0]    p_q;
	logic [ITER_W-1:0] it_q;
	logic [BIN_W-1:0]  bin_q;
	logic              conj_q;
	logic              ok_q;
	logic [3:0]        harm_cfg_q;
	logic [4:0]        bins_cfg_q;
	logic [31:0]       pow_cfg_q;

	logic [4:0]        nb;
	logic [HARM_W:0]   nh;
	logic [3:0]        nib;
	logic [POW_W:0]    np;
	logic              accept;
	logic              fill_drop;
	logic [BIN_W-1:0]  fill_bin;
	logic [BIN_W-1:0]  read_bin;
	logic [HARM_W:0]   rd_mag;
	logic              last_p;
	logic              last_h;

	assign accept     = item_valid && item_ready;
	assign item_ready = (state_q == ST_IDLE);
	assign cfg_ready  = 1'b1;

	always_comb begin
		if (bins_cfg_q == 5'd0) begin
			nb = 5'd1;
		end else if (bins_cfg_q > 5'(MAX_BINS)) begin
			nb = 5'(MAX_BINS);
		end else begin
			nb = bins_cfg_q;
		end
		nh  = (harm_cfg_q > 4'(MAX_HARMONICS)) ? 4'(MAX_HARMONICS) : harm_cfg_q;
		nib = pow_cfg_q[{h_q[HARM_W-1:0], 2'b00} +: 4];
		np  = (nib > 4'(MAX_POWERS)) ? 4'(MAX_POWERS) : nib;
	end

	// A single bin in use folds every fill onto bin 0; otherwise unused bins drop.
	assign fill_drop = (nb != 5'd1) && ({1'b0, item.bin_index} >= nb);
	assign fill_bin  = (nb == 5'd1) ? '0 : item.bin_index;
	assign read_bin  = ({1'b0, item.bin_index} >= nb) ? '0 : item.bin_index;
	assign rd_mag    = item.read_harmonic[3] ? (~item.read_harmonic + 4'd1)
	                                         : item.read_harmonic;
	assign last_p    = ((p_q + 4'd1) >= np);
	assign last_h    = ((h_q + 4'd1) >= nh);

	always_comb begin
		cmd           = '0;
		cmd.addr      = (state_q == ST_CLEAR) ? cnt_q
		                : {bin_q, h_q[HARM_W-1:0], p_q[POW_W-1:0]};
		cmd.p         = p_q[POW_W-1:0];
		cmd.iter      = it_q;
		cmd.bin       = bin_q;
		cmd.read_ok   = ok_q;
		cmd.read_conj = conj_q;
		case (state_q)
			ST_CLEAR: cmd.clr_wr = 1'b1;
			ST_IDLE: begin
				cmd.bin = fill_bin;
				if (accept && item.operation == OP_FILL && !fill_drop) begin
					cmd.load_fill = 1'b1;
				end
				if (accept && item.operation == OP_CLEAR) begin
					cmd.clear_all = 1'b1;
				end
			end
			ST_PRE:  cmd.pre_step  = 1'b1;
			ST_TSET: cmd.trig_init = 1'b1;
			ST_TRIG: cmd.trig_step = 1'b1;
			ST_TFIN: begin
				cmd.trig_fin = 1'b1;
				cmd.next_h   = (np == '0);
			end
			ST_RD:   cmd.mem_re = 1'b1;
			ST_MUL:  cmd.mul    = 1'b1;
			ST_WR: begin
				cmd.mem_we = 1'b1;
				cmd.next_h = last_p;
			end
			ST_RREQ: cmd.mem_re   = 1'b1;
			ST_RRES: cmd.load_out = !status.out_busy;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			harm_cfg_q <= HARM_RESET;
			bins_cfg_q <= BINS_RESET;
			pow_cfg_q  <= POWERS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_HARMONICS: harm_cfg_q <= cfg_data[3:0];
				CFG_BINS:      bins_cfg_q <= cfg_data[4:0];
				CFG_POWERS:    pow_cfg_q  <= cfg_data;
				default:       ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			cnt_q   <= '0;
			h_q     <= '0;
			p_q     <= '0;
			it_q    <= '0;
			bin_q   <= '0;
			conj_q  <= 1'b0;
			ok_q    <= 1'b0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == {ADDR_W{1'b1}}) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						case (item.operation)
							OP_FILL: begin
								if (!fill_drop) begin
									bin_q   <= fill_bin;
									p_q     <= '0;
									state_q <= ST_PRE;
								end
							end
							OP_CLEAR: begin
								cnt_q   <= '0;
								state_q <= ST_CLEAR;
							end
							OP_READ: begin
								bin_q   <= read_bin;
								h_q     <= rd_mag;
								p_q     <= {1'b0, item.read_power};
								conj_q  <= item.read_harmonic[3];
								ok_q    <= (rd_mag < 4'(MAX_HARMONICS));
								state_q <= ST_RREQ;
							end
							default: ;
						endcase
					end
				end
				ST_PRE: begin
					if (p_q == 4'(MAX_POWERS - 1)) begin
						p_q     <= '0;
						h_q     <= '0;
						state_q <= (nh == '0) ? ST_IDLE : ST_TSET;
					end else begin
						p_q <= p_q + 4'd1;
					end
				end
				ST_TSET: begin
					it_q    <= '0;
					state_q <= ST_TRIG;
				end
				ST_TRIG: begin
					if (it_q == 4'(CORDIC_STEPS - 1)) begin
						state_q <= ST_TFIN;
					end else begin
						it_q <= it_q + 4'd1;
					end
				end
				ST_TFIN: begin
					p_q <= '0;
					if (np != '0) begin
						state_q <= ST_RD;
					end else if (last_h) begin
						state_q <= ST_IDLE;
					end else begin
						h_q     <= h_q + 4'd1;
						state_q <= ST_TSET;
					end
				end
				ST_RD:  state_q <= ST_MUL;
				ST_MUL: state_q <= ST_WR;
				ST_WR: begin
					if (!last_p) begin
						p_q     <= p_q + 4'd1;
						state_q <= ST_RD;
					end else if (last_h) begin
						state_q <= ST_IDLE;
					end else begin
						h_q     <= h_q + 4'd1;
						state_q <= ST_TSET;
					end
				end
				ST_RREQ: state_q <= ST_RRES;
				ST_RRES: begin
					if (!status.out_busy) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`FQVA_ASSERT_IMP(a_no_rw_clash, cmd.mem_we || cmd.clr_wr, !cmd.mem_re, "memory read and write in one cycle")
	`FQVA_ASSERT_IMP(a_load_free, cmd.load_out, !status.out_busy, "result loaded over a pending beat")
	`FQVA_ASSERT_NEXT(a_read_seq, accept && item.operation == OP_READ, state_q == ST_RREQ, "read beat did not start a lookup")

endmodule

// ===== rtl/core/fqva_dp.sv =====
// ----------------------------------------------------------------------------
// fqva_dp
// Datapath: prefactor chain, CORDIC, sum memory and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fqva_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  fqva_pkg::item_t     item,
	input  fqva_pkg::cmd_t      cmd,
	output fqva_pkg::status_t   status,
	output logic                result_valid,
	input  logic                result_ready,
	output fqva_pkg::result_t   result
);
	import fqva_pkg::*;

	localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
	localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

	logic [15:0]              angle_q;
	logic [15:0]              w_q;
	logic [15:0]              sw_q;
	logic [15:0]              phase_q;
	logic [PRE_W-1:0]         pw_q;
	logic [PRE_W-1:0]         sp_q;
	logic [PRE_W-1:0]         pre_q [MAX_POWERS];
	logic signed [CX_W-1:0]   x_q;
	logic signed [CX_W-1:0]   y_q;
	logic signed [Z_W-1:0]    z_q;
	logic                     neg_q;
	logic                     spec_q;
	logic signed [TRIG_W-1:0] spec_c_q;
	logic signed [TRIG_W-1:0] spec_s_q;
	logic signed [TRIG_W-1:0] c_q;
	logic signed [TRIG_W-1:0] s_q;
	logic [2*SUM_W-1:0]       mem [DEPTH];
	logic [2*SUM_W-1:0]       rdata_q;
	logic signed [SUM_W:0]    term_re_q;
	logic signed [SUM_W:0]    term_im_q;
	logic [MAX_BINS-1:0]      flags_q;
	logic [31:0]              count_q;
	logic                     result_valid_q;
	result_t                  result_q;

	logic signed [Z_W-1:0]    z0;
	logic signed [CX_W-1:0]   dx;
	logic signed [CX_W-1:0]   dy;
	logic signed [Z_W-1:0]    atan;
	logic signed [CX_W-1:0]   xr;
	logic signed [CX_W-1:0]   yr;
	logic signed [TRIG_W-1:0] c_new;
	logic signed [TRIG_W-1:0] s_new;
	logic signed [SUM_W-1:0]  rd_re;
	logic signed [SUM_W-1:0]  rd_im;
	logic signed [SUM_W-1:0]  wr_re;
	logic signed [SUM_W-1:0]  wr_im;
	logic signed [SUM_W-1:0]  im_conj;

	function automatic logic signed [TRIG_W-1:0] clamp15(input logic signed [CX_W-1:0] v);
		if (v > 34'sd32767) begin
			return 16'sd32767;
		end else if (v < -34'sd32767) begin
			return -16'sd32767;
		end
		return v[TRIG_W-1:0];
	endfunction

	function automatic logic signed [SUM_W-1:0] sat_add(input logic signed [SUM_W-1:0] a,
	                                                    input logic signed [SUM_W:0] b);
		logic signed [SUM_W+1:0] s;
		s = {{2{a[SUM_W-1]}}, a} + {b[SUM_W], b};
		if (s > $signed({2'b00, SUM_MAX})) begin
			return SUM_MAX;
		end else if (s < $signed({2'b11, SUM_MIN})) begin
			return SUM_MIN;
		end
		return s[SUM_W-1:0];
	endfunction

	// Fold the phase into the right half plane; the far half flips both outputs.
	always_comb begin
		z0 = {{(Z_W-16){phase_q[15]}}, phase_q};
		if (z0 > 18'sd16384) begin
			z0 = z0 - 18'sd32768;
		end else if (z0 < -18'sd16384) begin
			z0 = z0 + 18'sd32768;
		end
	end

	assign dx    = y_q >>> cmd.iter;
	assign dy    = x_q >>> cmd.iter;
	assign atan  = atan_step(cmd.iter);
	assign xr    = (x_q + 34'sd16384) >>> 15;
	assign yr    = (y_q + 34'sd16384) >>> 15;
	assign c_new = neg_q ? -clamp15(xr) : clamp15(xr);
	assign s_new = neg_q ? -clamp15(yr) : clamp15(yr);

	assign rd_re   = rdata_q[2*SUM_W-1:SUM_W];
	assign rd_im   = rdata_q[SUM_W-1:0];
	assign wr_re   = sat_add(rd_re, term_re_q);
	assign wr_im   = sat_add(rd_im, term_im_q);
	assign im_conj = (rd_im == SUM_MIN) ? SUM_MAX : -rd_im;

	always_ff @(posedge clk) begin
		if (cmd.load_fill) begin
			angle_q <= item.angle;
			w_q     <= item.weight;
			sw_q    <= item.second_weight;
			phase_q <= '0;
			pw_q    <= ONE_Q12;
			sp_q    <= ONE_Q12;
		end
		if (cmd.pre_step) begin
			pre_q[cmd.p] <= (sw_q != '0 && cmd.p > 3'd1) ? qmul(sp_q, w_q) : pw_q;
			pw_q         <= qmul(pw_q, w_q);
			if (cmd.p >= 3'd1) begin
				sp_q <= qmul(sp_q, sw_q);
			end
		end
		if (cmd.next_h) begin
			phase_q <= phase_q + angle_q;
		end
		if (cmd.trig_init) begin
			x_q      <= CORDIC_X0;
			y_q      <= '0;
			z_q      <= z0;
			neg_q    <= (z0 != {{(Z_W-16){phase_q[15]}}, phase_q});
			spec_q   <= (phase_q[13:0] == '0);
			spec_c_q <= (phase_q[15:14] == 2'd0) ? 16'sd32767
			            : (phase_q[15:14] == 2'd2) ? -16'sd32767 : 16'sd0;
			spec_s_q <= (phase_q[15:14] == 2'd1) ? 16'sd32767
			            : (phase_q[15:14] == 2'd3) ? -16'sd32767 : 16'sd0;
		end
		if (cmd.trig_step) begin
			if (z_q >= 0) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - atan;
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + atan;
			end
		end
		if (cmd.trig_fin) begin
			c_q <= spec_q ? spec_c_q : c_new;
			s_q <= spec_q ? spec_s_q : s_new;
		end
		if (cmd.mul) begin
			term_re_q <= $signed({1'b0, pre_q[cmd.p]}) * c_q;
			term_im_q <= $signed({1'b0, pre_q[cmd.p]}) * s_q;
		end
		if (cmd.load_out) begin
			result_q.sum_real   <= cmd.read_ok ? rd_re : '0;
			result_q.sum_imag   <= !cmd.read_ok ? '0 : (cmd.read_conj ? im_conj : rd_im);
			result_q.bin_filled <= flags_q[cmd.bin];
			result_q.fill_count <= count_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.clr_wr) begin
			mem[cmd.addr] <= '0;
		end else if (cmd.mem_we) begin
			mem[cmd.addr] <= {wr_re, wr_im};
		end
		if (cmd.mem_re) begin
			rdata_q <= mem[cmd.addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q        <= '0;
			count_q        <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (cmd.clear_all) begin
				flags_q <= '0;
				count_q <= '0;
			end else if (cmd.load_fill) begin
				flags_q[cmd.bin] <= 1'b1;
				if (count_q != '1) begin
					count_q <= count_q + 32'd1;
				end
			end
			if (cmd.load_out) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	assign status.out_busy = result_valid_q && !result_ready;
	assign result_valid    = result_valid_q;
	assign result          = result_q;

endmodule

// ===== rtl/core/flow_q_vector_accumulator.sv =====
// ----------------------------------------------------------------------------
// flow_q_vector_accumulator
// Weighted complex Q-vector sums per momentum bin, harmonic and weight power.
// ----------------------------------------------------------------------------
// After reset the block sweeps its 1024-entry sum memory to zero, one entry a
// cycle, and takes no item until the sweep ends; a clear item starts the same
// sweep. A read looks up the stored sum, waits until any earlier result beat
// is taken, and then puts its result in an output register, so the next item
// may enter while the beat waits. A fill first builds the prefactors of all
// eight powers, then per active harmonic runs the 14-step CORDIC and, for each
// active power, a single-port read-modify-write of the stored sum.
// Configuration writes are taken in any cycle and must only be issued while
// the block is idle.
`timescale 1ns / 1ps

module flow_q_vector_accumulator (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           item_valid,
	output logic                           item_ready,
	input  fqva_pkg::item_t                item,
	output logic                           result_valid,
	input  logic                           result_ready,
	output fqva_pkg::result_t              result,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [fqva_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                    cfg_data
);
	import fqva_pkg::*;

	cmd_t    cmd;
	status_t status;

	fqva_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.cmd        (cmd),
		.status     (status)
	);

	fqva_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.cmd          (cmd),
		.status       (status),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule
